@@ design/plti_pkg.sv @@
package plti_pkg;

    // Fixed field widths
    localparam int DATA_W   = 32;
    localparam int FRAC_W   = 16;
    localparam int FUNC_W   = 3;
    localparam int ROW_W    = 6;
    localparam int COL_W    = 3;
    localparam int RIU_W    = 7;
    localparam int APB_W    = 32;
    localparam int PADDR_W  = 3;

    // Default table geometry
    localparam int DEF_ROWS = 64;
    localparam int DEF_COLS = 8;

    // Register index of rows_in_use (paddr[2] selects the register)
    localparam logic [0:0] REG_ROWS_IN_USE = 1'b0;

    // Command codes
    typedef enum logic [FUNC_W-1:0] {
        FUNC_WR_TIME  = 3'd0,
        FUNC_WR_VALUE = 3'd1,
        FUNC_RD_TIME  = 3'd2,
        FUNC_RD_VALUE = 3'd3,
        FUNC_INTERP   = 3'd4
    } t_func;

endpackage

@@ design/piecewise_linear_table_interpolator.sv @@
// Time or value reads pass the RAM read register, S_RD_RES, S_PUT; writes land in S_IDLE.
// Interpolation: an upward scan over the time memory (one row per read), then the
// 16-step serial divider.
// One command is in flight at a time; a finished word waits in the output register.
// Synchronous active-low reset; afterwards a clearing pass zeroes both memories, walking
// ROWS << max(1, ceil(log2(COLS))) value addresses (512 at defaults); no word is taken.
module piecewise_linear_table_interpolator import plti_pkg::*; #(
    parameter int ROWS = DEF_ROWS,
    parameter int COLS = DEF_COLS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [FUNC_W-1:0]  i_func,
    input  logic [ROW_W-1:0]   i_row,
    input  logic [COL_W-1:0]   i_column,
    input  logic signed [DATA_W-1:0] i_operand,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [DATA_W-1:0] o_result,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [APB_W-1:0]   pwdata,
    output logic [APB_W-1:0]   prdata,
    output logic               pready
);

    localparam int RW     = $clog2(ROWS);
    localparam int CW     = (COLS > 1) ? $clog2(COLS) : 1;
    localparam int VAW    = RW + CW;
    localparam int VDEPTH = ROWS << CW;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_RD_RES, S_LAST, S_FIRST, S_SCAN,
        S_DIV, S_V0, S_V1, S_ADD, S_PUT
    } t_state;

    t_state            r_state;
    logic [VAW-1:0]    r_clr;
    logic [CW-1:0]     r_col_a;
    logic [RW-1:0]     r_k;
    logic signed [DATA_W-1:0] r_t;
    logic signed [DATA_W-1:0] r_t_prev;
    logic signed [DATA_W-1:0] r_v0;
    logic [DATA_W-1:0] r_delta;
    logic [DATA_W-1:0] r_acc;
    logic [FRAC_W-1:0] r_frac;
    logic              r_src_val;
    logic              r_out_valid;
    logic [DATA_W-1:0] r_result;
    logic [RIU_W-1:0]  r_rows_in_use;

    // Memory ports
    logic              t_we, v_we;
    logic [RW-1:0]     t_addr;
    logic [VAW-1:0]    v_addr;
    logic [DATA_W-1:0] t_wdata, v_wdata;
    logic [DATA_W-1:0] t_q, v_q;
    logic signed [DATA_W-1:0] t_q_s, v_q_s;

    // Divider port
    logic              div_start, div_done;
    logic [DATA_W-1:0] div_num, div_den;
    logic [FRAC_W-1:0] div_quot;

    // Decoded input and table bounds
    logic              in_fire;
    logic [RW+ROW_W-1:0] row_x;
    logic [CW+COL_W-1:0] col_x;
    logic              row_ok, col_ok;
    logic [RW-1:0]     row_a;
    logic [CW-1:0]     col_a;
    logic [RW+RIU_W:0] riu_x;
    logic [RW+RIU_W:0] n_sat;
    logic [RW:0]       n_use;
    logic [RW:0]       n_last_x;
    logic [RW-1:0]     n_last;
    logic [RW-1:0]     km1;
    logic              scan_go;
    logic signed [DATA_W:0] num_x, den_x, dv_x;
    logic signed [DATA_W+FRAC_W+1:0] prod;
    logic              cfg_wr;

    assign in_fire  = i_in_valid && o_in_ready;
    assign row_x    = (RW + ROW_W)'(i_row);
    assign col_x    = (CW + COL_W)'(i_column);
    assign row_ok   = row_x < (RW + ROW_W)'(ROWS);
    assign col_ok   = col_x < (CW + COL_W)'(COLS);
    assign row_a    = row_x[RW-1:0];
    assign col_a    = col_x[CW-1:0];

    // Saturate rows_in_use to the table depth
    assign riu_x    = (RW + RIU_W + 1)'(r_rows_in_use);
    assign n_sat    = (riu_x > (RW + RIU_W + 1)'(ROWS)) ? (RW + RIU_W + 1)'(ROWS) : riu_x;
    assign n_use    = n_sat[RW:0];
    assign n_last_x = n_use - (RW + 1)'(1);
    assign n_last   = n_last_x[RW-1:0];
    assign km1      = r_k - RW'(1);

    assign t_q_s    = $signed(t_q);
    assign v_q_s    = $signed(v_q);
    assign scan_go  = ({1'b0, r_k} < n_last_x) && (r_t >= t_q_s);

    // Span of the bracketing pair and offset of the query, both non-negative
    assign num_x    = {r_t[DATA_W-1], r_t} - {r_t_prev[DATA_W-1], r_t_prev};
    assign den_x    = {t_q_s[DATA_W-1], t_q_s} - {r_t_prev[DATA_W-1], r_t_prev};
    assign div_num  = num_x[DATA_W-1:0];
    assign div_den  = den_x[DATA_W-1:0];

    // Value step times fraction; floor shift keeps the low word of the delta
    assign dv_x     = {v_q_s[DATA_W-1], v_q_s} - {r_v0[DATA_W-1], r_v0};
    assign prod     = dv_x * $signed({1'b0, r_frac});

    // Drive memory addresses and writes per state
    always_comb begin
        t_we      = 1'b0;
        v_we      = 1'b0;
        t_addr    = r_k;
        v_addr    = {r_k, r_col_a};
        t_wdata   = i_operand;
        v_wdata   = i_operand;
        div_start = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                t_we    = 1'b1;
                v_we    = 1'b1;
                t_addr  = r_clr[VAW-1:CW];
                v_addr  = r_clr;
                t_wdata = '0;
                v_wdata = '0;
            end
            S_IDLE: begin
                if (in_fire) begin
                    unique case (i_func)
                        FUNC_WR_TIME: begin
                            t_we   = row_ok;
                            t_addr = row_a;
                        end
                        FUNC_WR_VALUE: begin
                            v_we   = row_ok && col_ok;
                            v_addr = {row_a, col_a};
                        end
                        FUNC_RD_TIME:  t_addr = row_a;
                        FUNC_RD_VALUE: v_addr = {row_a, col_a};
                        FUNC_INTERP:   t_addr = n_last;
                        default: ;
                    endcase
                end
            end
            S_LAST: begin
                if (r_t >= t_q_s) begin
                    v_addr = {n_last, r_col_a};
                end else begin
                    t_addr = '0;
                end
            end
            S_FIRST: begin
                if (r_t <= t_q_s) begin
                    v_addr = {RW'(0), r_col_a};
                end else begin
                    t_addr = RW'(1);
                end
            end
            S_SCAN: begin
                if (scan_go) begin
                    t_addr = r_k + RW'(1);
                end else if (t_q_s <= r_t_prev) begin
                    v_addr = {km1, r_col_a};
                end else begin
                    div_start = 1'b1;
                end
            end
            S_DIV:   v_addr = {km1, r_col_a};
            S_V0:    v_addr = {r_k, r_col_a};
            default: ;
        endcase
    end

    // Sequencer: state, working registers and the output word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // Load the output word from the put state, drop it once taken
            if (r_state == S_PUT && (!r_out_valid || i_out_ready)) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + VAW'(1);
                    if (r_clr == VAW'(VDEPTH - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (in_fire) begin
                        r_col_a <= col_a;
                        r_t     <= i_operand;
                        unique case (i_func)
                            FUNC_RD_TIME: begin
                                r_src_val <= 1'b0;
                                r_acc     <= '0;
                                r_state   <= row_ok ? S_RD_RES : S_PUT;
                            end
                            FUNC_RD_VALUE: begin
                                r_src_val <= 1'b1;
                                r_acc     <= '0;
                                r_state   <= (row_ok && col_ok) ? S_RD_RES : S_PUT;
                            end
                            FUNC_INTERP: begin
                                r_acc   <= '0;
                                r_state <= (n_use == '0 || !col_ok) ? S_PUT : S_LAST;
                            end
                            default: ;
                        endcase
                    end
                end
                S_RD_RES: begin
                    r_acc   <= r_src_val ? v_q : t_q;
                    r_state <= S_PUT;
                end
                S_LAST: begin
                    r_src_val <= 1'b1;
                    r_state   <= (r_t >= t_q_s) ? S_RD_RES : S_FIRST;
                end
                S_FIRST: begin
                    if (r_t <= t_q_s) begin
                        r_state <= S_RD_RES;
                    end else begin
                        r_t_prev <= t_q_s;
                        r_k      <= RW'(1);
                        r_state  <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (scan_go) begin
                        r_t_prev <= t_q_s;
                        r_k      <= r_k + RW'(1);
                    end else if (t_q_s <= r_t_prev) begin
                        r_state <= S_RD_RES;
                    end else begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        r_frac  <= div_quot;
                        r_state <= S_V0;
                    end
                end
                S_V0: begin
                    r_v0    <= v_q_s;
                    r_state <= S_V1;
                end
                S_V1: begin
                    r_delta <= prod[DATA_W+FRAC_W-1:FRAC_W];
                    r_state <= S_ADD;
                end
                S_ADD: begin
                    r_acc   <= r_v0 + r_delta;
                    r_state <= S_PUT;
                end
                S_PUT: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_result <= r_acc;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Configuration register
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_ROWS_IN_USE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_in_use <= '0;
        end else if (cfg_wr) begin
            r_rows_in_use <= pwdata[RIU_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_ROWS_IN_USE) ? {{(APB_W - RIU_W){1'b0}}, r_rows_in_use}
                                                  : '0;
    assign pready = 1'b1;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_result    = $signed(r_result);

    plti_ram #(
        .WIDTH (DATA_W),
        .DEPTH (ROWS)
    ) u_times (
        .i_clk   (i_clk),
        .i_we    (t_we),
        .i_addr  (t_addr),
        .i_wdata (t_wdata),
        .o_rdata (t_q)
    );

    plti_ram #(
        .WIDTH (DATA_W),
        .DEPTH (VDEPTH)
    ) u_values (
        .i_clk   (i_clk),
        .i_we    (v_we),
        .i_addr  (v_addr),
        .i_wdata (v_wdata),
        .o_rdata (v_q)
    );

    plti_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

`ifndef SYNTH
    // Divider finishes only while the sequencer waits for it
    a_div_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == S_DIV))
        else $error("divider finished outside its wait state");

    // Scan index stays inside the used rows
    a_scan_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_k != '0 && {1'b0, r_k} <= n_last_x))
        else $error("scan index left the used rows");

    // Value memory is written only by commands or the clearing pass
    a_value_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        v_we |-> (r_state == S_IDLE || r_state == S_CLEAR))
        else $error("value memory written during a lookup");

    // A result leaves the put state into the output register
    a_put_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PUT && (!o_out_valid || i_out_ready))
            |=> (o_out_valid && r_state == S_IDLE))
        else $error("result not loaded into the output register");
`endif

endmodule

@@ design/plti_ram.sv @@
module plti_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write at the address, register the old contents for the read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ design/plti_div.sv @@
module plti_div import plti_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DATA_W-1:0] i_num,
    input  logic [DATA_W-1:0] i_den,
    output logic              o_done,
    output logic [FRAC_W-1:0] o_quot
);

    localparam int CNT_W = $clog2(FRAC_W);

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [DATA_W-1:0] r_rem;
    logic [DATA_W-1:0] r_den;
    logic [FRAC_W-1:0] r_quot;

    logic [DATA_W:0]   shifted;
    logic [DATA_W:0]   trial;
    logic              fits;
    logic [DATA_W-1:0] n_rem;

    // One quotient bit per cycle; the numerator stays below the divisor
    always_comb begin
        shifted = {r_rem, 1'b0};
        trial   = shifted - {1'b0, r_den};
        fits    = shifted >= {1'b0, r_den};
        n_rem   = fits ? trial[DATA_W-1:0] : shifted[DATA_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= i_num;
                r_den  <= i_den;
            end else if (r_busy) begin
                r_rem  <= n_rem;
                r_quot <= {r_quot[FRAC_W-2:0], fits};
                r_cnt  <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(FRAC_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

@@ dv/tb_piecewise_linear_table_interpolator.sv @@
module tb_piecewise_linear_table_interpolator;
    import plti_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int     SETTLE_CYCLES   = 128;
    localparam int     CYCLE_LIMIT     = 1_000_000;
    localparam int     ITEMS_PER_PHASE = 130;
    localparam int     NUM_PHASES      = 8;
    localparam longint TIME_FLOOR      = -64'sd2147483648;
    localparam logic [PADDR_W-1:0] ADDR_ROWS_IN_USE = {REG_ROWS_IN_USE, 2'b00};
    // Command codes the block must ignore
    localparam logic [FUNC_W-1:0]  FUNC_FIRST_UNUSED = 3'd5;
    localparam logic [FUNC_W-1:0]  FUNC_LAST_UNUSED  = 3'd7;

    logic                      i_clk      = 1'b0;
    logic                      i_rst_n    = 1'b0;
    logic                      i_in_valid = 1'b0;
    logic                      o_in_ready;
    logic [FUNC_W-1:0]         i_func     = '0;
    logic [ROW_W-1:0]          i_row      = '0;
    logic [COL_W-1:0]          i_column   = '0;
    logic signed [DATA_W-1:0]  i_operand  = '0;
    logic                      o_out_valid;
    logic                      i_out_ready = 1'b0;
    logic signed [DATA_W-1:0]  o_result;
    logic                      psel    = 1'b0;
    logic                      penable = 1'b0;
    logic                      pwrite  = 1'b0;
    logic [PADDR_W-1:0]        paddr   = '0;
    logic [APB_W-1:0]          pwdata  = '0;
    logic [APB_W-1:0]          prdata;
    logic                      pready;

    // Mirror of the breakpoint table and its setting
    logic signed [DATA_W-1:0]  bp_time  [DEF_ROWS];
    logic signed [DATA_W-1:0]  bp_value [DEF_ROWS*DEF_COLS];
    logic [RIU_W-1:0]          rows_setting;
    logic [DATA_W-1:0]         pending_results[$];
    logic [DATA_W-1:0]         want_result;

    int          mismatch_count = 0;
    int unsigned cycle_count    = 0;
    int          burst_left     = 0;
    int          stall_mode     = 0;
    int          stall_left     = 0;

    piecewise_linear_table_interpolator i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_func      (i_func),
        .i_row       (i_row),
        .i_column    (i_column),
        .i_operand   (i_operand),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_result    (o_result),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always #2 i_clk = ~i_clk;

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Receiver back-pressure: switch between stall patterns every so often
    always @(posedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode <= $urandom_range(0, 3);
            stall_left <= $urandom_range(16, 200);
        end else begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            0: i_out_ready <= 1'b1;
            1: i_out_ready <= 1'($urandom_range(0, 1));
            2: i_out_ready <= (cycle_count[2:0] == 3'd0);
            default: i_out_ready <= ($urandom_range(0, 15) == 0);
        endcase
    end

    // Compare each returned word with the oldest pending expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h", $time, o_result);
                mismatch_count++;
            end else begin
                want_result = pending_results.pop_front();
                if (o_result !== want_result) begin
                    $display("%0t: result mismatch, expected %h, actual %h",
                             $time, want_result, o_result);
                    mismatch_count++;
                end
            end
        end
    end

    // Interpolated value at a query time in one column
    function automatic logic [DATA_W-1:0] interp_value(logic signed [DATA_W-1:0] query,
                                                       int col);
        int     n;
        int     k;
        longint q;
        longint t0;
        longint t1;
        longint v0;
        longint v1;
        longint frac;
        longint prod;
        n = (rows_setting > DEF_ROWS) ? DEF_ROWS : int'(rows_setting);
        if (n == 0)
            return '0;
        q  = query;
        t1 = bp_time[n-1];
        if (q >= t1)
            return bp_value[(n-1)*DEF_COLS + col];
        t0 = bp_time[0];
        if (q <= t0)
            return bp_value[col];
        // Scan upward for the first row whose time exceeds the query
        k = 0;
        while (k < n - 1) begin
            t1 = bp_time[k];
            if (q < t1)
                break;
            k++;
        end
        if (k == 0)
            k = 1;
        t0 = bp_time[k-1];
        t1 = bp_time[k];
        if (t1 <= t0)
            return bp_value[(k-1)*DEF_COLS + col];
        frac = ((q - t0) << FRAC_W) / (t1 - t0);
        if (frac > 65535)
            frac = 65535;
        v0   = bp_value[(k-1)*DEF_COLS + col];
        v1   = bp_value[k*DEF_COLS + col];
        prod = (v1 - v0) * frac;
        return DATA_W'(v0 + (prod >>> FRAC_W));
    endfunction

    // Update the table mirror and queue the result the word causes.
    // ROWS and COLS cover the whole row and column fields, so no index is out of range.
    function automatic void apply_command(logic [FUNC_W-1:0] func, logic [ROW_W-1:0] row,
                                          logic [COL_W-1:0] col,
                                          logic [DATA_W-1:0] operand);
        case (func)
            FUNC_WR_TIME:  bp_time[row] = operand;
            FUNC_WR_VALUE: bp_value[row*DEF_COLS + col] = operand;
            FUNC_RD_TIME:  pending_results.push_back(bp_time[row]);
            FUNC_RD_VALUE: pending_results.push_back(bp_value[row*DEF_COLS + col]);
            FUNC_INTERP:   pending_results.push_back(interp_value(operand, col));
            default: ;
        endcase
    endfunction

    function automatic logic [DATA_W-1:0] random_value();
        int unsigned pick;
        pick = $urandom_range(0, 9);
        if (pick == 0)
            return {1'b1, {(DATA_W-1){1'b0}}};
        if (pick == 1)
            return {1'b0, {(DATA_W-1){1'b1}}};
        return $urandom;
    endfunction

    // Query time: mostly inside the used span, some at breakpoints, ends and anywhere
    function automatic logic [DATA_W-1:0] table_query(int n);
        int unsigned pick;
        longint      lo;
        longint      hi;
        pick = $urandom_range(0, 99);
        if (n == 0 || pick < 15)
            return $urandom;
        lo = bp_time[0];
        hi = bp_time[n-1];
        if (pick < 30)
            return bp_time[$urandom_range(0, n - 1)];
        if (hi <= lo)
            return $urandom;
        if (pick < 40)
            return DATA_W'(($urandom_range(0, 1) ? lo : hi) + longint'($urandom_range(0, 2)) - 1);
        return DATA_W'(lo + longint'($urandom_range(0, 32'(hi - lo))));
    endfunction

    // Present one word in bursts with random gaps, wait for accept, then predict
    task automatic send_word(input logic [FUNC_W-1:0] func, input logic [ROW_W-1:0] row,
                             input logic [COL_W-1:0] col, input logic [DATA_W-1:0] operand);
        int gap;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200)
                                                      : $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_in_valid <= 1'b1;
        i_func     <= func;
        i_row      <= row;
        i_column   <= col;
        i_operand  <= operand;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        apply_command(func, row, col, operand);
    endtask

    // Hold off until every result is back and any trailing write has retired
    task automatic wait_table_idle();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_rows_in_use(input logic [RIU_W-1:0] value);
        wait_table_idle();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_ROWS_IN_USE;
        pwdata  <= APB_W'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        rows_setting = value;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic reset_table();
        for (int r = 0; r < DEF_ROWS; r++)
            bp_time[r] = '0;
        for (int i = 0; i < DEF_ROWS*DEF_COLS; i++)
            bp_value[i] = '0;
        rows_setting = '0;
        i_rst_n <= 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // Wait out the clearing pass
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
    endtask

    // Non-decreasing times for the used rows, then values in two columns
    task automatic load_table(input int n, input logic [COL_W-1:0] col_a,
                              input logic [COL_W-1:0] col_b);
        longint max_step;
        longint room;
        longint t;
        if (n == 0)
            return;
        if ($urandom_range(0, 1))
            max_step = $urandom_range(1, 32'h0004_0000);
        else
            max_step = (64'sh1_0000_0000 - 64'sh40_0000) / n;
        room = 64'shFFFF_FFFF - n * max_step;
        t    = TIME_FLOOR + longint'($urandom_range(0, 32'(room)));
        for (int r = 0; r < n; r++) begin
            send_word(FUNC_WR_TIME, ROW_W'(r), COL_W'($urandom), DATA_W'(t));
            t += longint'($urandom_range(0, 32'(max_step)));
        end
        for (int r = 0; r < n; r++) begin
            send_word(FUNC_WR_VALUE, ROW_W'(r), col_a, random_value());
            send_word(FUNC_WR_VALUE, ROW_W'(r), col_b, random_value());
        end
    endtask

    // One random word: half lookups, mostly in the loaded columns, plus reads, writes, noise
    task automatic random_command(input int n, input logic [COL_W-1:0] col_a,
                                  input logic [COL_W-1:0] col_b);
        int unsigned       pick;
        logic [COL_W-1:0]  col;
        logic [ROW_W-1:0]  row;
        logic [FUNC_W-1:0] func;
        pick = $urandom_range(0, 99);
        col  = ($urandom_range(0, 4) != 0) ? ($urandom_range(0, 1) ? col_a : col_b)
                                            : COL_W'($urandom);
        row  = (n != 0 && $urandom_range(0, 3) != 0) ? ROW_W'($urandom_range(0, n - 1))
                                                      : ROW_W'($urandom);
        if (pick < 50) begin
            send_word(FUNC_INTERP, ROW_W'($urandom), col, table_query(n));
        end else if (pick < 64) begin
            send_word(FUNC_WR_VALUE, row, col, random_value());
        end else if (pick < 68) begin
            send_word(FUNC_WR_TIME, row, COL_W'($urandom), random_value());
        end else if (pick < 80) begin
            send_word(FUNC_RD_TIME, row, COL_W'($urandom), $urandom);
        end else if (pick < 94) begin
            send_word(FUNC_RD_VALUE, row, col, $urandom);
        end else begin
            func = FUNC_W'($urandom_range(FUNC_FIRST_UNUSED, FUNC_LAST_UNUSED));
            send_word(func, row, col, $urandom);
        end
    endtask

    // Empty table answers zero; untouched entries read back as zero
    task automatic test_empty_table();
        write_rows_in_use('0);
        send_word(FUNC_INTERP, '0, '1, 32'h7FFF_FFFF);
        send_word(FUNC_INTERP, '1, '0, 32'h8000_0000);
        send_word(FUNC_RD_TIME, ROW_W'(10), '0, '0);
        send_word(FUNC_RD_VALUE, ROW_W'(40), COL_W'(5), '0);
    endtask

    // Field extremes, clamping at both ends, exact breakpoint, ignored codes
    task automatic test_table_edges();
        write_rows_in_use(RIU_W'(3));
        send_word(FUNC_WR_TIME,  '0, '0, 32'h8000_0000);
        send_word(FUNC_WR_TIME,  ROW_W'(1), '0, 32'h0000_0000);
        send_word(FUNC_WR_TIME,  ROW_W'(2), '0, 32'h7FFF_FFFF);
        send_word(FUNC_WR_VALUE, '0, '1, 32'h7FFF_FFFF);
        send_word(FUNC_WR_VALUE, ROW_W'(1), '1, 32'h8000_0000);
        send_word(FUNC_WR_VALUE, ROW_W'(2), '1, 32'h1234_5678);
        send_word(FUNC_WR_VALUE, '1, '0, 32'hFFFF_FFFF);
        send_word(FUNC_WR_TIME,  '1, '1, 32'h5555_AAAA);
        send_word(FUNC_RD_TIME,  '1, '0, '0);
        send_word(FUNC_RD_VALUE, '1, '0, '0);
        send_word(FUNC_RD_VALUE, ROW_W'(1), '1, '0);
        send_word(FUNC_INTERP, '0, '1, 32'h8000_0000);
        send_word(FUNC_INTERP, '0, '1, 32'h7FFF_FFFF);
        send_word(FUNC_INTERP, '0, '1, 32'hC000_0000);
        send_word(FUNC_INTERP, '0, '1, 32'h4000_0000);
        send_word(FUNC_INTERP, '0, '1, 32'h0000_0000);
        send_word(FUNC_INTERP, '0, '1, 32'h0000_0001);
        for (int f = FUNC_FIRST_UNUSED; f <= FUNC_LAST_UNUSED; f++)
            send_word(FUNC_W'(f), '1, '1, '1);
    endtask

    // Out-of-order times: the scan stops at the first time above the query
    task automatic test_unsorted_times();
        write_rows_in_use(RIU_W'(4));
        send_word(FUNC_WR_TIME,  '0, '0, 32'h0000_0000);
        send_word(FUNC_WR_TIME,  ROW_W'(1), '0, 32'h0064_0000);
        send_word(FUNC_WR_TIME,  ROW_W'(2), '0, 32'h0032_0000);
        send_word(FUNC_WR_TIME,  ROW_W'(3), '0, 32'h00C8_0000);
        send_word(FUNC_WR_VALUE, ROW_W'(3), '1, 32'h0100_0000);
        send_word(FUNC_INTERP, '0, '1, 32'h004B_0000);
        send_word(FUNC_INTERP, '0, '1, 32'h0096_0000);
    endtask

    // Random phases over several row counts, full and saturating ones included
    task automatic test_random_phases();
        int               phase_rows[NUM_PHASES] = '{64, 1, 2, 127, 9, 0, 33, 17};
        int               n;
        logic [COL_W-1:0] col_a;
        logic [COL_W-1:0] col_b;
        phase_rows[NUM_PHASES-1] = $urandom_range(3, 63);
        for (int p = 0; p < NUM_PHASES; p++) begin
            write_rows_in_use(RIU_W'(phase_rows[p]));
            n     = (phase_rows[p] > DEF_ROWS) ? DEF_ROWS : phase_rows[p];
            col_a = COL_W'($urandom);
            col_b = COL_W'($urandom);
            load_table(n, col_a, col_b);
            for (int i = 0; i < ITEMS_PER_PHASE; i++)
                random_command(n, col_a, col_b);
        end
    endtask

    initial begin
        reset_table();
        test_empty_table();
        test_table_edges();
        test_unsorted_times();
        test_random_phases();
        wait_table_idle();
        if (mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
